@@ src/nfa_pkg.sv @@
// Shared types and constants for the epsilon-NFA simulator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package nfa_pkg;

	// Item kinds carried on the input tuser field.
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_START   = 2'd1;
	localparam logic [1:0] KIND_CONSUME = 2'd2;

	// Width of the mask-shaped fields and registers on the ports.
	localparam int MASK_BITS = 16;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_UNION,
		ST_CLOSE,
		ST_FINISH
	} nfa_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;     // latch the input transfer into the item registers
		logic clear_step;  // zero one table word and advance the clear counter
		logic row_write;   // write one transition row from the item registers
		logic rd_sym;      // read the table word of the item's symbol
		logic rd_eps;      // read the epsilon table word
		logic set_start;   // active set becomes the start state alone
		logic set_union;   // active set becomes the union of its successor rows
		logic set_grow;    // active set grows by one epsilon step
		logic set_bad;     // empty the active set and flag a bad symbol
		logic out_load;    // move the result into the output register
	} nfa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       clear_last;  // clear counter is on the last table word
		logic [1:0] kind;        // kind of the captured item
		logic       sym_ok;      // captured symbol is in the alphabet
		logic       closed;      // one more epsilon step would add nothing
		logic       out_free;    // output register can take a result this cycle
	} nfa_stat_t;

endpackage

@@ src/nfa_ctrl.sv @@
// Controller state machine of the epsilon-NFA simulator.
// Sequences the datapath through commands; depends on nfa_pkg.
`timescale 1ns / 1ps

module nfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  nfa_pkg::nfa_stat_t st,
	output nfa_pkg::nfa_cmd_t  cmd
);

	nfa_pkg::nfa_state_t state_q;
	nfa_pkg::nfa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nfa_pkg::ST_CLEAR: begin
				if (st.clear_last) begin
					state_d = nfa_pkg::ST_IDLE;
				end
			end
			nfa_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = nfa_pkg::ST_DISPATCH;
				end
			end
			nfa_pkg::ST_DISPATCH: begin
				unique case (st.kind)
					nfa_pkg::KIND_START: state_d = nfa_pkg::ST_CLOSE;
					nfa_pkg::KIND_CONSUME: begin
						state_d = st.sym_ok ? nfa_pkg::ST_UNION : nfa_pkg::ST_FINISH;
					end
					default: state_d = nfa_pkg::ST_FINISH;
				endcase
			end
			nfa_pkg::ST_UNION: state_d = nfa_pkg::ST_CLOSE;
			nfa_pkg::ST_CLOSE: begin
				if (st.closed) begin
					state_d = nfa_pkg::ST_FINISH;
				end
			end
			nfa_pkg::ST_FINISH: begin
				if (st.out_free) begin
					state_d = nfa_pkg::ST_IDLE;
				end
			end
			default: state_d = nfa_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			nfa_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			nfa_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.capture = s_axis_tvalid;
			end
			nfa_pkg::ST_DISPATCH: begin
				unique case (st.kind)
					nfa_pkg::KIND_WRITE: cmd.row_write = 1'b1;
					nfa_pkg::KIND_START: begin
						cmd.set_start = 1'b1;
						cmd.rd_eps = 1'b1;
					end
					nfa_pkg::KIND_CONSUME: begin
						cmd.rd_sym = st.sym_ok;
						cmd.set_bad = !st.sym_ok;
					end
					default: cmd = '0;
				endcase
			end
			nfa_pkg::ST_UNION: begin
				cmd.set_union = 1'b1;
				cmd.rd_eps = 1'b1;
			end
			nfa_pkg::ST_CLOSE: cmd.set_grow = !st.closed;
			nfa_pkg::ST_FINISH: cmd.out_load = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

@@ src/nfa_dp.sv @@
// Datapath of the epsilon-NFA simulator: configuration registers, transition
// memory, active-set register, row-union unit and output register; uses nfa_pkg.
`timescale 1ns / 1ps

module nfa_dp #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic [31:0]        s_axis_tdata,
	input  logic [1:0]         s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [23:0]        m_axis_tdata,
	input  nfa_pkg::nfa_cmd_t  cmd,
	output nfa_pkg::nfa_stat_t st
);

	localparam int DEPTH   = NUM_SYMBOLS + 1;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int STATE_W = $clog2(NUM_STATES);
	localparam int WORD_W  = NUM_STATES * NUM_STATES;

	localparam logic [1:0] CFG_START    = 2'd0;
	localparam logic [1:0] CFG_ACCEPT   = 2'd1;
	localparam logic [1:0] CFG_ALPHABET = 2'd2;

	// Configuration registers.
	logic [3:0]  start_q;
	logic [15:0] accept_q;
	logic [15:0] alphabet_q;

	// Captured item.
	logic [1:0]  kind_q;
	logic [4:0]  sym_q;
	logic [3:0]  from_q;
	logic [15:0] next_q;

	// One word per symbol code, holding the rows of all states side by side.
	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] sym_addr;
	logic [STATE_W-1:0] from_idx;
	logic              row_ok;

	logic [NUM_STATES-1:0] set_q;
	logic                  bad_q;
	logic [NUM_STATES-1:0] union_v;
	logic [NUM_STATES-1:0] grow_v;
	logic [NUM_STATES-1:0] start_v;
	logic [15:0]           act16;

	logic        out_valid_q;
	logic        out_acc_q;
	logic [15:0] out_act_q;
	logic        out_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			accept_q   <= '0;
			alphabet_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START:    start_q    <= cfg_wdata[3:0];
				CFG_ACCEPT:   accept_q   <= cfg_wdata;
				CFG_ALPHABET: alphabet_q <= cfg_wdata;
				default:      start_q    <= start_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= s_axis_tuser;
			sym_q  <= s_axis_tdata[4:0];
			from_q <= s_axis_tdata[8:5];
			next_q <= s_axis_tdata[24:9];
		end
	end

	assign sym_addr = ADDR_W'(sym_q);
	assign from_idx = STATE_W'(from_q);
	assign row_ok   = (32'(from_q) < NUM_STATES) && (32'(sym_q) <= NUM_SYMBOLS);
	assign rd_addr  = cmd.rd_sym ? sym_addr : ADDR_W'(NUM_SYMBOLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_step) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem_q[clr_cnt_q] <= '0;
		end else if (cmd.row_write && row_ok) begin
			mem_q[sym_addr][from_idx*NUM_STATES +: NUM_STATES] <= NUM_STATES'(next_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_sym || cmd.rd_eps) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// Union of the rows of all active states in the word last read.
	always_comb begin
		union_v = '0;
		for (int s = 0; s < NUM_STATES; s++) begin
			if (set_q[s]) begin
				union_v = union_v | rdata_q[s*NUM_STATES +: NUM_STATES];
			end
		end
	end

	assign grow_v  = set_q | union_v;
	assign start_v = (32'(start_q) < NUM_STATES) ?
		(NUM_STATES'(1) << start_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q <= '0;
			bad_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				bad_q <= 1'b0;
			end else if (cmd.set_bad) begin
				bad_q <= 1'b1;
			end
			priority if (cmd.set_bad) begin
				set_q <= '0;
			end else if (cmd.set_start) begin
				set_q <= start_v;
			end else if (cmd.set_union) begin
				set_q <= union_v;
			end else if (cmd.set_grow) begin
				set_q <= grow_v;
			end
		end
	end

	assign act16 = 16'(set_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_acc_q <= |(act16 & accept_q);
			out_act_q <= act16;
			out_bad_q <= bad_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_bad_q, out_act_q, out_acc_q};

	assign st.clear_last = (clr_cnt_q == ADDR_W'(NUM_SYMBOLS));
	assign st.kind       = kind_q;
	assign st.sym_ok     = (32'(sym_q) < NUM_SYMBOLS) &&
		(32'(sym_q) < nfa_pkg::MASK_BITS) && alphabet_q[sym_q[3:0]];
	assign st.closed     = (grow_v == set_q);
	assign st.out_free   = !out_valid_q || m_axis_tready;

endmodule

@@ src/nfa_epsilon_simulator.sv @@
// Top level of the epsilon-NFA simulator: joins the controller and the datapath.
// Depends on nfa_pkg, nfa_ctrl and nfa_dp.
//
// Use: items arrive as transfers on the s_axis channel. tuser gives the kind
// (row write, start of a new string, consume a symbol) and tdata the symbol,
// source state and target mask. Every item yields exactly one result transfer
// on m_axis: the active set after the item, whether any active state accepts,
// and whether a consumed symbol was outside the alphabet.
// The configuration port writes the start state, accepting mask and alphabet
// mask, one register per write; write it only while no item is in flight.
// Sequence: a row write stores its row and goes straight to the output register;
// a start item loads the start state and closes it over epsilon moves; a consume
// item unites the active rows of its symbol's word and closes that, or empties
// the set for a symbol outside the alphabet. The closure runs one epsilon step
// per cycle through a single row-union unit fed from one registered memory read.
// Items are taken one at a time; the next one is taken as soon as the previous
// result sits in the output register, so a stalled receiver holds back only
// the item after that.
// After reset the transition memory is cleared, one word a cycle, from word 0
// to word NUM_SYMBOLS; s_axis_tready stays low until that is done.
`timescale 1ns / 1ps

module nfa_epsilon_simulator #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // symbol[4:0], from_state[8:5], next_mask[24:9]
	input  logic [1:0]  s_axis_tuser,  // kind[1:0]
	// Results.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // accepted[0], active_states[16:1], bad_symbol[17]
);

	nfa_pkg::nfa_cmd_t  cmd;
	nfa_pkg::nfa_stat_t st;

	// The controller owns the sequence; it raises tready only when idle.
	nfa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.st            (st),
		.cmd           (cmd)
	);

	// The datapath holds the table, the active set and the output register.
	nfa_dp #(
		.NUM_STATES  (NUM_STATES),
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cmd           (cmd),
		.st            (st)
	);

endmodule

@@ verif/nfa_epsilon_simulator_test.sv @@
// Self-checking testbench for the epsilon-NFA simulator: drives items, predicts every result
// with its own copy of the table, the active set and the registers, and compares the results.
// Depends on nfa_pkg and nfa_epsilon_simulator.
`timescale 1ns / 1ps

module nfa_epsilon_simulator_test;

	// Kind code that the block must treat as a no-op reporting like a row write.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_START_STATE   = 2'd0;
	localparam logic [1:0] REG_ACCEPT_MASK   = 2'd1;
	localparam logic [1:0] REG_ALPHABET_MASK = 2'd2;

	localparam int N_STATES  = 16;
	localparam int N_SYMBOLS = 16;
	// The extra table column that holds the epsilon moves.
	localparam logic [4:0] EPS_SYM = 5'd16;

	localparam int IDLE_PCT     = 27;
	localparam int RANDOM_ITEMS = 1900;
	localparam int MAX_PRINTED  = 30;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  symbol;
		logic [3:0]  from_state;
		logic [15:0] next_mask;
	} nfa_item_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] active_states;
		logic        bad_symbol;
	} nfa_result_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = '0;
	logic [15:0] cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;  // symbol[4:0], from_state[8:5], next_mask[24:9]
	logic [1:0]  s_axis_tuser  = '0;  // kind[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // accepted[0], active_states[16:1], bad_symbol[17]

	nfa_epsilon_simulator #(
		.NUM_STATES (N_STATES),
		.NUM_SYMBOLS(N_SYMBOLS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Items waiting to be offered, and the results that accepted items have yet to produce.
	nfa_item_t   pending_items[$];
	nfa_result_t awaited_results[$];

	// The predictor's own copy of the automaton: one target mask per state and symbol,
	// epsilon in the last column, plus the active set and the three registers.
	logic [15:0] trans_rows [0:N_STATES-1][0:N_SYMBOLS];
	logic [15:0] model_active;
	logic [3:0]  model_start;
	logic [15:0] model_accept;
	logic [15:0] model_alphabet;

	// When set, neither side of the bus idles.
	logic calm = 1'b0;

	nfa_item_t   item_on_bus;
	nfa_item_t   next_item;
	nfa_result_t predicted;
	nfa_result_t observed;
	nfa_result_t wanted;

	int mismatch_count = 0;
	int results_checked = 0;
	int accepted_seen = 0;
	int bad_seen = 0;
	int random_items = 0;
	int phase_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block stalls; a correct run ends well before this.
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Union of the rows of every state in the set for one table column.
	function automatic logic [15:0] successor_union(input logic [15:0] set,
		input logic [4:0] sym);
		logic [15:0] acc;
		acc = '0;
		for (int s = 0; s < N_STATES; s++)
			if (set[s])
				acc |= trans_rows[s][sym];
		return acc;
	endfunction

	// Grows the set over epsilon moves. Each step adds at least one state or changes nothing,
	// so N_STATES steps always reach the fixed point.
	function automatic logic [15:0] close_over_epsilon(input logic [15:0] set);
		logic [15:0] grown;
		grown = set;
		for (int i = 0; i < N_STATES; i++)
			grown = grown | successor_union(grown, EPS_SYM);
		return grown;
	endfunction

	// Applies one accepted item to the predictor and gives the result it must produce.
	task automatic advance_model(input nfa_item_t it, output nfa_result_t res);
		logic bad;
		bad = 1'b0;
		case (it.kind)
			nfa_pkg::KIND_WRITE: begin
				// Symbols past epsilon address nothing, so such a write is dropped.
				if (it.symbol <= EPS_SYM)
					trans_rows[it.from_state][it.symbol] = it.next_mask;
			end
			nfa_pkg::KIND_START: begin
				model_active = close_over_epsilon(16'(1) << model_start);
			end
			nfa_pkg::KIND_CONSUME: begin
				// Epsilon and anything above it can never be consumed.
				if (it.symbol < N_SYMBOLS && model_alphabet[it.symbol[3:0]]) begin
					model_active = close_over_epsilon(successor_union(model_active, it.symbol));
				end else begin
					bad = 1'b1;
					model_active = '0;
				end
			end
			default: ;
		endcase
		res.accepted      = |(model_active & model_accept);
		res.active_states = model_active;
		res.bad_symbol    = bad;
	endtask

	// Driver: offers the queued items, idling at random, and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_model(item_on_bus, predicted);
				awaited_results.push_back(predicted);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_item = pending_items.pop_front();
					item_on_bus   <= next_item;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {7'b0, next_item.next_mask, next_item.from_state,
						next_item.symbol};
					s_axis_tuser  <= next_item.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls the result side at random and checks every result transfer against the
	// oldest prediction, field by field.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				observed.accepted      = m_axis_tdata[0];
				observed.active_states = m_axis_tdata[16:1];
				observed.bad_symbol    = m_axis_tdata[17];
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result with no item outstanding, active %h",
						observed.active_states));
				end else begin
					wanted = awaited_results.pop_front();
					results_checked++;
					if (wanted.accepted) accepted_seen++;
					if (wanted.bad_symbol) bad_seen++;
					if (observed.accepted !== wanted.accepted)
						report_mismatch($sformatf("result %0d: accepted %b, predicted %b",
							results_checked, observed.accepted, wanted.accepted));
					if (observed.active_states !== wanted.active_states)
						report_mismatch($sformatf("result %0d: active_states %h, predicted %h",
							results_checked, observed.active_states, wanted.active_states));
					if (observed.bad_symbol !== wanted.bad_symbol)
						report_mismatch($sformatf("result %0d: bad_symbol %b, predicted %b",
							results_checked, observed.bad_symbol, wanted.bad_symbol));
				end
			end
			m_axis_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	task automatic queue_item(input logic [1:0] kind, input logic [4:0] sym,
		input logic [3:0] from, input logic [15:0] mask);
		nfa_item_t it;
		it.kind       = kind;
		it.symbol     = sym;
		it.from_state = from;
		it.next_mask  = mask;
		pending_items.push_back(it);
		// No-op kinds and writes past the epsilon column do nothing, so they are not counted.
		if (kind != KIND_UNUSED && !(kind == nfa_pkg::KIND_WRITE && sym > EPS_SYM))
			random_items++;
	endtask

	// Register writes only ever happen once the block has gone quiet.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_START_STATE:   model_start    = val[3:0];
			REG_ACCEPT_MASK:   model_accept   = val;
			REG_ALPHABET_MASK: model_alphabet = val;
			default: ;
		endcase
	endtask

	// Holds the sender back until every item has been offered and every result has come back.
	// Sampling just after the edge keeps this clear of the driver's own updates.
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() != 0 || awaited_results.size() != 0 || s_axis_tvalid);
		repeat (4) @(posedge clk);
	endtask

	// Mostly one or two targets so that the sets stay varied, with the odd empty or random row.
	function automatic logic [15:0] sparse_mask();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return 16'($urandom);
		else if (pick < 6)
			return 16'(1) << $urandom_range(0, 15);
		else
			return (16'(1) << $urandom_range(0, 15)) | (16'(1) << $urandom_range(0, 15));
	endfunction

	// Mostly a symbol of the current alphabet; otherwise any code, epsilon and above included.
	function automatic logic [4:0] pick_symbol();
		int s;
		if (model_alphabet != 0 && $urandom_range(0, 99) < 85) begin
			do s = $urandom_range(0, N_SYMBOLS - 1); while (!model_alphabet[s]);
			return 5'(s);
		end
		return 5'($urandom_range(0, 31));
	endfunction

	// One random phase: new register settings, a batch of row writes, then well-formed strings
	// (a start followed by symbols) and a little noise.
	task automatic run_random_phase(input int phase);
		int n_rows;
		int n_strings;
		int len;
		int s0;
		if (phase % 4 == 0) begin
			// Register extremes.
			write_reg(REG_START_STATE, $urandom_range(0, 1) ? 16'd15 : 16'd0);
			write_reg(REG_ACCEPT_MASK, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
			write_reg(REG_ALPHABET_MASK, $urandom_range(0, 3) != 0 ? 16'hFFFF : 16'h0000);
		end else begin
			write_reg(REG_START_STATE, 16'($urandom_range(0, 15)));
			write_reg(REG_ACCEPT_MASK, 16'($urandom & $urandom));
			write_reg(REG_ALPHABET_MASK, 16'($urandom | $urandom));
		end

		n_rows = $urandom_range(12, 40);
		repeat (n_rows)
			queue_item(nfa_pkg::KIND_WRITE,
				$urandom_range(0, 3) == 0 ? EPS_SYM : 5'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)), sparse_mask());
		// Now and then a chain of epsilon moves, so that the closure needs many steps.
		if ($urandom_range(0, 2) == 0) begin
			s0 = $urandom_range(0, 10);
			for (int s = s0; s < N_STATES - 1; s++)
				queue_item(nfa_pkg::KIND_WRITE, EPS_SYM, 4'(s), 16'(1) << (s + 1));
		end
		if (phase % 2 == 1)
			drain();

		n_strings = $urandom_range(4, 10);
		repeat (n_strings) begin
			queue_item(nfa_pkg::KIND_START, 5'($urandom_range(0, 31)),
				4'($urandom_range(0, 15)), 16'($urandom));
			len = $urandom_range(1, 12);
			repeat (len)
				queue_item(nfa_pkg::KIND_CONSUME, pick_symbol(), 4'($urandom_range(0, 15)),
					16'($urandom));
		end

		// Noise: any kind with any field values.
		repeat ($urandom_range(2, 8))
			queue_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
				4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0 ? 16'($urandom) : sparse_mask());
	endtask

	initial begin
		for (int s = 0; s < N_STATES; s++)
			for (int c = 0; c <= N_SYMBOLS; c++)
				trans_rows[s][c] = '0;
		model_active   = '0;
		model_start    = '0;
		model_accept   = '0;
		model_alphabet = 16'hFFFF;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, first with the reset settings. A consume on the empty set stays empty,
		// then an epsilon cycle 0 -> 1 -> 15 -> 0 is built and exercised.
		queue_item(nfa_pkg::KIND_CONSUME, 5'd0, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_START, 5'd0, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_WRITE, EPS_SYM, 4'd0, 16'h0002);
		queue_item(nfa_pkg::KIND_WRITE, EPS_SYM, 4'd1, 16'h8000);
		queue_item(nfa_pkg::KIND_WRITE, EPS_SYM, 4'd15, 16'h0001);
		queue_item(nfa_pkg::KIND_WRITE, 5'd15, 4'd15, 16'hFFFF);
		queue_item(nfa_pkg::KIND_WRITE, 5'd0, 4'd0, 16'h0004);
		// A write past the epsilon column must leave the table alone.
		queue_item(nfa_pkg::KIND_WRITE, 5'd31, 4'd2, 16'hFFFF);
		queue_item(KIND_UNUSED, 5'd31, 4'd15, 16'hFFFF);
		queue_item(nfa_pkg::KIND_START, 5'd0, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_CONSUME, 5'd15, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_CONSUME, 5'd0, 4'd0, 16'h0000);
		// Epsilon itself and codes above it are never part of the alphabet.
		queue_item(nfa_pkg::KIND_CONSUME, EPS_SYM, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_START, 5'd0, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_CONSUME, 5'd31, 4'd15, 16'hFFFF);
		drain();

		// Highest start state, every state accepting, a two-symbol alphabet.
		write_reg(REG_START_STATE, 16'd15);
		write_reg(REG_ACCEPT_MASK, 16'hFFFF);
		write_reg(REG_ALPHABET_MASK, 16'h8001);
		queue_item(nfa_pkg::KIND_START, 5'd0, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_CONSUME, 5'd15, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_CONSUME, 5'd1, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_START, 5'd0, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_CONSUME, 5'd0, 4'd0, 16'h0000);
		drain();

		// An empty alphabet turns every symbol away.
		write_reg(REG_ALPHABET_MASK, 16'h0000);
		queue_item(nfa_pkg::KIND_START, 5'd0, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_CONSUME, 5'd0, 4'd0, 16'h0000);
		queue_item(nfa_pkg::KIND_WRITE, 5'd0, 4'd0, 16'h0000);
		drain();

		// Random part. One phase runs with no idling on either side.
		random_items = 0;
		phase_count = 0;
		while (random_items < RANDOM_ITEMS) begin
			calm <= (phase_count == 3);
			run_random_phase(phase_count);
			drain();
			phase_count++;
		end
		calm <= 1'b0;
		repeat (40) @(posedge clk);

		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

		$display("Checked %0d results over %0d random phases and the directed part.",
			results_checked, phase_count);
		$display("Of these, %0d reported an accepting state and %0d a symbol outside the alphabet.",
			accepted_seen, bad_seen);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/nfa_pkg.sv
src/nfa_ctrl.sv
src/nfa_dp.sv
src/nfa_epsilon_simulator.sv
verif/nfa_epsilon_simulator_test.sv
